// ----- rtl/stlt_pkg.sv -----
// ----------------------------------------------------------------------------
// stlt_pkg: shared types and constants of the STA/LTA energy trigger
// Widths, register indexes, sequencer states and small helper functions.
// ----------------------------------------------------------------------------
package stlt_pkg;

    localparam int LONG_WINDOW_MAX = 4096;
    localparam int SAMPLE_BITS     = 16;
    localparam int ADDR_BITS       = $clog2(LONG_WINDOW_MAX);
    localparam int LEN_BITS        = ADDR_BITS + 1;
    localparam int THR_BITS        = 16;
    localparam int COUNT_BITS      = 24;
    localparam int CFG_BITS        = 24;
    localparam int CFG_IDX_BITS    = 2;
    localparam int MAG_BITS        = SAMPLE_BITS + 1;
    localparam int SQ_BITS         = 2 * SAMPLE_BITS;
    // one guard bit above the window sum for the add before the saturating subtract
    localparam int SUM_BITS        = SQ_BITS + ADDR_BITS + 1;
    localparam int MUL_BITS        = 32;
    localparam int PROD_BITS       = 2 * MUL_BITS;
    localparam int K_BITS          = THR_BITS + LEN_BITS;
    localparam int ACC_BITS        = K_BITS + SUM_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STA_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LTA_LENGTH      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_INDEX     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SQ_SHORT,
        S_SQ_LONG,
        S_UPDATE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_MUL5,
        S_COMPARE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   re;
        logic [ADDR_BITS-1:0]   raddr_a;
        logic [ADDR_BITS-1:0]   raddr_b;
        logic                   we;
        logic [ADDR_BITS-1:0]   waddr;
        logic [SAMPLE_BITS-1:0] wdata;
    } t_hist_req;

    // magnitude of a two's complement sample, one bit wider than the sample
    function automatic logic [MAG_BITS-1:0] stlt_mag(input logic [SAMPLE_BITS-1:0] raw);
        logic [MAG_BITS-1:0] ext;
        ext = {raw[SAMPLE_BITS-1], raw};
        return raw[SAMPLE_BITS-1] ? (~ext + MAG_BITS'(1)) : ext;
    endfunction

    // clamp a window length into 1 .. LONG_WINDOW_MAX
    function automatic logic [LEN_BITS-1:0] stlt_eff_len(input logic [LEN_BITS-1:0] len);
        if (len == '0) begin
            return LEN_BITS'(1);
        end else if (len > LEN_BITS'(LONG_WINDOW_MAX)) begin
            return LEN_BITS'(LONG_WINDOW_MAX);
        end
        return len;
    endfunction

endpackage

// ----- rtl/stlt_mul.sv -----
// ----------------------------------------------------------------------------
// stlt_mul: shared unsigned multiplier
// One 32 by 32 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module stlt_mul import stlt_pkg::*; (
    input  logic                 i_clk,
    input  logic [MUL_BITS-1:0]  i_a,
    input  logic [MUL_BITS-1:0]  i_b,
    output logic [PROD_BITS-1:0] o_p
);

    logic [PROD_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_BITS'(i_a) * PROD_BITS'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/stlt_hist.sv -----
// ----------------------------------------------------------------------------
// stlt_hist: sample delay line
// One write port and two registered read ports over the long window store.
// ----------------------------------------------------------------------------
module stlt_hist import stlt_pkg::*; (
    input  logic                   i_clk,
    input  t_hist_req              i_req,
    output logic [SAMPLE_BITS-1:0] o_rd_a,
    output logic [SAMPLE_BITS-1:0] o_rd_b
);

    logic [SAMPLE_BITS-1:0] r_mem [LONG_WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_rd_a;
    logic [SAMPLE_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // hold read data until the next read so a later write cannot alter it
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_a <= r_mem[i_req.raddr_a];
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ----- rtl/sta_lta_energy_trigger.sv -----
// ----------------------------------------------------------------------------
// sta_lta_energy_trigger: STA/LTA trigger on squared samples
// Each item steps through the sequencer states (read, squares, window update, then
// the ratio products and compare when eligible) to S_DONE, which holds until the output
// register is free; no new item is taken before then. One 32x32 multiplier serves every product.
// Reset (synchronous, active low) loads default registers and empties the record.
// ----------------------------------------------------------------------------
module sta_lta_energy_trigger import stlt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    // input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [15:0]             s_axis_tdata,   // [15:0] sample
    input  logic                    s_axis_tuser,   // [0] first_in_record
    input  logic                    s_axis_tlast,   // last_in_record
    // result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // [23:0] trigger_index
    output logic [1:0]              m_axis_tuser    // [0] trigger, [1] no_trigger
);

    // configuration registers
    logic [LEN_BITS-1:0]    r_sta_len;
    logic [LEN_BITS-1:0]    r_lta_len;
    logic [THR_BITS-1:0]    r_thr;
    logic [COUNT_BITS-1:0]  r_start;

    // record state
    logic [SUM_BITS-1:0]    r_short;
    logic [SUM_BITS-1:0]    r_long;
    logic [COUNT_BITS-1:0]  r_count;
    logic [ADDR_BITS-1:0]   r_wp;
    logic [LEN_BITS-1:0]    r_fill;     // samples written since the record began, saturating
    logic                   r_fired;

    // item in flight
    t_state                 r_state;
    t_state                 n_state;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_last;
    logic [COUNT_BITS-1:0]  r_idx;
    logic                   r_vs;
    logic                   r_vl;
    logic [K_BITS-1:0]      r_k;
    logic [ACC_BITS-1:0]    r_acc_l;
    logic [ACC_BITS-1:0]    r_acc_r;
    logic                   r_hit;

    // output register
    logic                   r_out_valid;
    logic                   r_out_trig;
    logic                   r_out_none;
    logic [COUNT_BITS-1:0]  r_out_idx;

    logic [LEN_BITS-1:0]    sl;
    logic [LEN_BITS-1:0]    ll;
    logic [ADDR_BITS-1:0]   addr_s;
    logic [ADDR_BITS-1:0]   addr_l;
    logic                   in_acc;
    logic                   out_free;
    logic                   eligible;
    logic [SUM_BITS-1:0]    sq;
    logic [MAG_BITS-1:0]    mag_s;
    logic [MAG_BITS-1:0]    mag_l;
    logic [MUL_BITS-1:0]    mul_a;
    logic [MUL_BITS-1:0]    mul_b;
    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS-1:0] rd_s;
    logic [SAMPLE_BITS-1:0] rd_l;
    t_hist_req              hist_req;

    assign sl       = stlt_eff_len(r_sta_len);
    assign ll       = stlt_eff_len(r_lta_len);
    // the leaving sample sits one window length behind the write pointer
    assign addr_s   = r_wp - sl[ADDR_BITS-1:0];
    assign addr_l   = r_wp - ll[ADDR_BITS-1:0];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign eligible = !r_fired && (r_start >= COUNT_BITS'(ll)) && (r_idx >= r_start);
    assign sq       = SUM_BITS'(prod[SQ_BITS-1:0]);
    // entries not written since the record began read as zero
    assign mag_s    = r_vs ? stlt_mag(rd_s) : '0;
    assign mag_l    = r_vl ? stlt_mag(rd_l) : '0;

    stlt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    stlt_hist u_hist (
        .i_clk  (i_clk),
        .i_req  (hist_req),
        .o_rd_a (rd_s),
        .o_rd_b (rd_l)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state, multiplier operands, delay line port
    always_comb begin
        n_state          = r_state;
        mul_a            = '0;
        mul_b            = '0;
        hist_req.re      = 1'b0;
        hist_req.raddr_a = addr_s;
        hist_req.raddr_b = addr_l;
        hist_req.we      = 1'b0;
        hist_req.waddr   = r_wp;
        hist_req.wdata   = r_sample;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // square of the arriving sample; fetch both leaving samples
                hist_req.re = 1'b1;
                mul_a       = MUL_BITS'(stlt_mag(r_sample));
                mul_b       = MUL_BITS'(stlt_mag(r_sample));
                n_state     = S_SQ_SHORT;
            end
            S_SQ_SHORT: begin
                // leaving samples are read, overwrite the slot now
                hist_req.we = 1'b1;
                mul_a       = MUL_BITS'(mag_s);
                mul_b       = MUL_BITS'(mag_s);
                n_state     = S_SQ_LONG;
            end
            S_SQ_LONG: begin
                mul_a   = MUL_BITS'(mag_l);
                mul_b   = MUL_BITS'(mag_l);
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                mul_a   = MUL_BITS'(r_thr);
                mul_b   = MUL_BITS'(sl);
                n_state = eligible ? S_MUL1 : S_DONE;
            end
            S_MUL1: begin
                mul_a   = r_short[MUL_BITS-1:0];
                mul_b   = MUL_BITS'(ll);
                n_state = (r_long == '0) ? S_DONE : S_MUL2;
            end
            S_MUL2: begin
                mul_a   = MUL_BITS'(r_short[SUM_BITS-1:MUL_BITS]);
                mul_b   = MUL_BITS'(ll);
                n_state = S_MUL3;
            end
            S_MUL3: begin
                mul_a   = MUL_BITS'(r_k);
                mul_b   = r_long[MUL_BITS-1:0];
                n_state = S_MUL4;
            end
            S_MUL4: begin
                mul_a   = MUL_BITS'(r_k);
                mul_b   = MUL_BITS'(r_long[SUM_BITS-1:MUL_BITS]);
                n_state = S_MUL5;
            end
            S_MUL5: begin
                n_state = S_COMPARE;
            end
            S_COMPARE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sta_len   <= LEN_BITS'(40);
            r_lta_len   <= LEN_BITS'(1000);
            r_thr       <= THR_BITS'(1024);
            r_start     <= COUNT_BITS'(1000);
            r_short     <= '0;
            r_long      <= '0;
            r_count     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_fired     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STA_LENGTH:      r_sta_len <= i_cfg_data[LEN_BITS-1:0];
                    CFG_LTA_LENGTH:      r_lta_len <= i_cfg_data[LEN_BITS-1:0];
                    CFG_RATIO_THRESHOLD: r_thr     <= i_cfg_data[THR_BITS-1:0];
                    CFG_START_INDEX:     r_start   <= i_cfg_data[COUNT_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            // drain the output register; a result loaded in S_DONE refills it
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
                        r_last   <= s_axis_tlast;
                        r_idx    <= s_axis_tuser ? '0 : r_count;
                        // a new record empties the window before this item counts
                        if (s_axis_tuser) begin
                            r_short <= '0;
                            r_long  <= '0;
                            r_count <= '0;
                            r_wp    <= '0;
                            r_fill  <= '0;
                            r_fired <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    r_vs <= r_fill[ADDR_BITS] || ({1'b0, addr_s} < r_fill);
                    r_vl <= r_fill[ADDR_BITS] || ({1'b0, addr_l} < r_fill);
                end
                S_SQ_SHORT: begin
                    // add the arriving square to both windows
                    r_short <= r_short + sq;
                    r_long  <= r_long + sq;
                end
                S_SQ_LONG: begin
                    r_short <= (r_short >= sq) ? r_short - sq : '0;
                end
                S_UPDATE: begin
                    r_long <= (r_long >= sq) ? r_long - sq : '0;
                    r_wp   <= r_wp + ADDR_BITS'(1);
                    if (!r_fill[ADDR_BITS]) begin
                        r_fill <= r_fill + LEN_BITS'(1);
                    end
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                    r_hit <= 1'b0;
                end
                S_MUL1: begin
                    r_k <= prod[K_BITS-1:0];
                    // an empty long window counts as ratio zero
                    if (r_long == '0) begin
                        r_hit <= (r_thr == '0);
                    end
                end
                S_MUL2: begin
                    r_acc_l <= ACC_BITS'(prod);
                end
                S_MUL3: begin
                    r_acc_l <= r_acc_l + ACC_BITS'({prod, {MUL_BITS{1'b0}}});
                end
                S_MUL4: begin
                    r_acc_r <= ACC_BITS'(prod);
                end
                S_MUL5: begin
                    r_acc_r <= r_acc_r + ACC_BITS'({prod, {MUL_BITS{1'b0}}});
                end
                S_COMPARE: begin
                    // scale the short side by 256 for the Q8.8 threshold
                    r_hit <= ({r_acc_l[ACC_BITS-9:0], 8'b0} >= r_acc_r);
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_trig  <= r_hit;
                        r_out_idx   <= r_idx;
                        r_out_none  <= r_last && !(r_fired || r_hit);
                        r_fired     <= r_fired || r_hit;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // take no item while reset is held
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_idx;
    assign m_axis_tuser  = {r_out_none, r_out_trig};

endmodule

// ----- rtl/stlt_check.sv -----
// ----------------------------------------------------------------------------
// stlt_check: port-level checks of the STA/LTA energy trigger
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module stlt_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while item in flight");

    // a record cannot both trigger and report no trigger on one item
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("trigger and no_trigger set together");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sta_lta_energy_trigger stlt_check u_stlt_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
